FILE: src/swaq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swaq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned FAULT_W = 2;
  localparam int unsigned OPK_W   = 3;

  typedef enum logic [OPK_W-1:0] {
    OP_ADD = 3'd0,
    OP_MIN = 3'd1,
    OP_MAX = 3'd2,
    OP_AND = 3'd3,
    OP_OR  = 3'd4,
    OP_XOR = 3'd5
  } op_kind_e;

  localparam logic OPC_PUSH = 1'b0;
  localparam logic OPC_POP  = 1'b1;

  localparam logic [FAULT_W-1:0] FAULT_OK    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd2;

  // Operands are zero-extended to 64 bits; mask trims the add to the data width.
  // Unused operator codes fall back to add.
  function automatic logic [63:0] combine(logic [OPK_W-1:0] op, logic [63:0] a,
                                          logic [63:0] b, logic [63:0] mask);
    logic [63:0] r;
    case (op)
      OP_MIN:  r = (a < b) ? a : b;
      OP_MAX:  r = (a > b) ? a : b;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      default: r = (a + b) & mask;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/swaq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swaq_req_if;
  import swaq_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

interface swaq_rsp_if;
  import swaq_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] fold;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, fold, count, is_empty, fault, input ready);
  modport sink   (input valid, fold, count, is_empty, fault, output ready);
endinterface

`default_nettype wire

FILE: src/swaq_core.sv
`timescale 1ns / 1ps
`default_nettype none

module swaq_core
  import swaq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned WIDTH    = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [OPK_W-1:0] op_kind_i,
  swaq_req_if.sink              req_i,
  swaq_rsp_if.source            rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned DW = $clog2(CAPACITY + 1);
  localparam int unsigned TW = DW + 1;
  localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
  localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_POPRD = 2'd1;
  localparam logic [1:0] ST_XFER  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  function automatic logic [WIDTH-1:0] comb_w(logic [OPK_W-1:0] op, logic [WIDTH-1:0] a,
                                              logic [WIDTH-1:0] b);
    return WIDTH'(combine(op, 64'(a), 64'(b), VMASK));
  endfunction

  logic [1:0]       state_q, state_d;
  logic [DW-1:0]    back_depth_q, back_depth_d;
  logic [DW-1:0]    front_depth_q, front_depth_d;
  logic [DW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [DW-1:0]    wr_cnt_q, wr_cnt_d;
  logic [FAULT_W-1:0] fault_q, fault_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] back_top_q, back_top_d;
  logic [WIDTH-1:0] front_top_q, front_top_d;
  logic [WIDTH-1:0] sfx_q, sfx_d;

  logic [VALUE_W-1:0] fold_q;
  logic [COUNT_W-1:0] count_q;
  logic               is_empty_q;
  logic [FAULT_W-1:0] rsp_fault_q;

  // back stack values and front stack suffix folds
  logic [WIDTH-1:0] bv_mem_q [CAPACITY];
  logic [WIDTH-1:0] fs_mem_q [CAPACITY];
  logic             bv_we, bv_re, fs_we, fs_re;
  logic [AW-1:0]    bv_waddr, bv_raddr, fs_waddr, fs_raddr;
  logic [WIDTH-1:0] bv_wdata, fs_wdata;
  logic [WIDTH-1:0] bv_rdata_q, fs_rdata_q;

  logic [TW-1:0]    total;
  logic [DW-1:0]    bd_m1, fd_m2, xfer_addr;
  logic [WIDTH-1:0] x_val, sfx_new, fold_w;
  logic             load;

  assign total     = TW'(back_depth_q) + TW'(front_depth_q);
  assign bd_m1     = back_depth_q - DW'(1);
  assign fd_m2     = front_depth_q - DW'(2);
  assign xfer_addr = bd_m1 - rd_cnt_q;
  assign x_val     = WIDTH'(64'(req_i.value));
  assign sfx_new   = (wr_cnt_q == '0) ? bv_rdata_q : comb_w(op_kind_i, bv_rdata_q, sfx_q);

  always_comb begin
    if (front_depth_q == '0 && back_depth_q == '0) begin
      fold_w = '0;
    end else if (front_depth_q == '0) begin
      fold_w = back_top_q;
    end else if (back_depth_q == '0) begin
      fold_w = front_top_q;
    end else begin
      fold_w = comb_w(op_kind_i, front_top_q, back_top_q);
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    back_depth_d  = back_depth_q;
    front_depth_d = front_depth_q;
    rd_cnt_d      = rd_cnt_q;
    wr_cnt_d      = wr_cnt_q;
    fault_d       = fault_q;
    back_top_d    = back_top_q;
    front_top_d   = front_top_q;
    sfx_d         = sfx_q;
    bv_we         = 1'b0;
    bv_re         = 1'b0;
    fs_we         = 1'b0;
    fs_re         = 1'b0;
    bv_waddr      = back_depth_q[AW-1:0];
    bv_raddr      = bd_m1[AW-1:0];
    fs_waddr      = wr_cnt_q[AW-1:0];
    fs_raddr      = fd_m2[AW-1:0];
    bv_wdata      = x_val;
    fs_wdata      = sfx_new;
    load          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          fault_d = FAULT_OK;
          state_d = ST_DONE;
          if (req_i.opcode == OPC_PUSH) begin
            if (total >= CAP_T) begin
              fault_d = FAULT_FULL;
            end else begin
              bv_we        = 1'b1;
              back_top_d   = (back_depth_q == '0) ? x_val : comb_w(op_kind_i, back_top_q, x_val);
              back_depth_d = back_depth_q + DW'(1);
            end
          end else if (total == '0) begin
            fault_d = FAULT_EMPTY;
          end else if (front_depth_q != '0) begin
            front_depth_d = front_depth_q - DW'(1);
            // new front top sits one below the entry being dropped
            if (front_depth_q >= DW'(2)) begin
              fs_re   = 1'b1;
              state_d = ST_POPRD;
            end
          end else begin
            // front empty: move the back stack across, newest first
            bv_re    = 1'b1;
            rd_cnt_d = DW'(1);
            wr_cnt_d = '0;
            state_d  = ST_XFER;
          end
        end
      end
      ST_POPRD: begin
        front_top_d = fs_rdata_q;
        state_d     = ST_DONE;
      end
      ST_XFER: begin
        fs_we    = 1'b1;
        sfx_d    = sfx_new;
        wr_cnt_d = wr_cnt_q + DW'(1);
        if (rd_cnt_q < back_depth_q) begin
          bv_re    = 1'b1;
          bv_raddr = xfer_addr[AW-1:0];
          rd_cnt_d = rd_cnt_q + DW'(1);
        end
        if (wr_cnt_q == bd_m1) begin
          // oldest entry is popped at once; sfx_q holds the suffix below it
          front_depth_d = bd_m1;
          back_depth_d  = '0;
          front_top_d   = sfx_q;
          state_d       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      back_depth_q  <= '0;
      front_depth_q <= '0;
      rd_cnt_q      <= '0;
      wr_cnt_q      <= '0;
      fault_q       <= FAULT_OK;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      back_depth_q  <= back_depth_d;
      front_depth_q <= front_depth_d;
      rd_cnt_q      <= rd_cnt_d;
      wr_cnt_q      <= wr_cnt_d;
      fault_q       <= fault_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    back_top_q  <= back_top_d;
    front_top_q <= front_top_d;
    sfx_q       <= sfx_d;
    if (load) begin
      fold_q      <= VALUE_W'(64'(fold_w));
      count_q     <= COUNT_W'(total);
      is_empty_q  <= (total == '0);
      rsp_fault_q <= fault_q;
    end
  end

  // Push writes only the back store, transfer reads it; transfer writes only
  // the front store, pops read it. No same-entry overlap is possible.
  always_ff @(posedge clk_i) begin
    if (bv_we) bv_mem_q[bv_waddr] <= bv_wdata;
    if (bv_re) bv_rdata_q <= bv_mem_q[bv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem_q[fs_waddr] <= fs_wdata;
    if (fs_re) fs_rdata_q <= fs_mem_q[fs_raddr];
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.fold     = fold_q;
  assign rsp_o.count    = count_q;
  assign rsp_o.is_empty = is_empty_q;
  assign rsp_o.fault    = rsp_fault_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= CAP_T)
    else $error("stored count exceeds capacity");

  a_xfer_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_XFER) |-> (front_depth_q == '0 && back_depth_q != '0))
    else $error("transfer with non-empty front or empty back");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && req_i.valid) |=> (state_q != ST_IDLE))
    else $error("accepted item did not start");

  a_poprd_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POPRD) |-> $past(fs_re))
    else $error("front top captured without a read");

endmodule

`default_nettype wire

FILE: src/sliding_window_aggregate_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    opcode, value
// rsp_o     out  valid/ready    fold, count, is_empty, fault
// apb       in   psel/penable   op_kind at byte address 0
//
// One item at a time. Push: IDLE, DONE. Pop with a non-empty front stack: IDLE,
// POPRD (one front store read for the new top, if two or more were held), DONE.
// Pop, empty front: IDLE, XFER (one back read, one front write per cycle), DONE.
// The next item is taken while the last result waits in the output register;
// a stalled result holds the block in its final cycle only.
// Reset clears the depths and op_kind; the stores need no clearing pass.

module sliding_window_aggregate_queue_top
  import swaq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned WIDTH    = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  swaq_req_if.sink         req_i,
  swaq_rsp_if.source       rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [OPK_W-1:0] op_kind_q;
  logic             reg_sel;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - OPK_W){1'b0}}, op_kind_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_kind_q <= OP_ADD;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      op_kind_q <= pwdata[OPK_W-1:0];
    end
  end

  swaq_core #(
    .CAPACITY (CAPACITY),
    .WIDTH    (WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_kind_i (op_kind_q),
    .req_i     (req_i),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire
